>>> sv/dbat_pkg.sv
// shared codes, widths and control types of the demand bound admission test
package dbat_pkg;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_TEST   = 2'd2;

   localparam int FIELD_BITS = 16;
   localparam int COUNT_BITS = 7;

   // one step of the demand sweep over the deadline-sorted window table
   typedef struct packed {
      logic start;
      logic step;
      logic last;
   } sweep_ctl_type;

endpackage

>>> sv/dbat_chan_if.sv
// request and response channel interfaces of the admission test
interface dbat_req_chan;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      mode;
   logic [dbat_pkg::FIELD_BITS-1:0] release_req;
   logic [dbat_pkg::FIELD_BITS-1:0] deadline;
   logic [dbat_pkg::FIELD_BITS-1:0] duration;

   modport source (output valid, mode, release_req, deadline, duration, input ready);
   modport sink (input valid, mode, release_req, deadline, duration, output ready);
endinterface

interface dbat_rsp_chan;
   logic                            valid;
   logic                            ready;
   logic                            feasible;
   logic                            overflow;
   logic [dbat_pkg::COUNT_BITS-1:0] window_count;

   modport source (output valid, feasible, overflow, window_count, input ready);
   modport sink (input valid, feasible, overflow, window_count, output ready);
endinterface

>>> sv/dbat_check.sv
// demand accumulator and overload compare for one start slot
module dbat_check #(
   parameter int MAX_WINDOWS = 64,
   parameter int SLOT_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dbat_pkg::sweep_ctl_type sweep_ctl,
   input  logic [SLOT_BITS-1:0]    lo,
   input  logic [SLOT_BITS-1:0]    fe,
   input  logic [SLOT_BITS-1:0]    dl_limit,
   input  logic [SLOT_BITS-1:0]    ent_rel,
   input  logic [SLOT_BITS-1:0]    ent_dl,
   input  logic [SLOT_BITS-1:0]    ent_dur,
   output logic                    fail
);

   localparam int SW = SLOT_BITS;
   localparam int DW = SLOT_BITS + $clog2(MAX_WINDOWS);

   logic [DW-1:0] acc_ff, acc_in;
   logic [SW-1:0] prev_dl_ff, prev_dl_in;
   logic          have_prev_ff, have_prev_in;
   logic [SW-1:0] lower;
   logic [SW-1:0] slack;
   logic          in_range;
   logic          take;

   // smallest end slot in the span where the demand stays constant
   assign lower    = (have_prev_ff && (prev_dl_ff > fe)) ? prev_dl_ff : fe;
   assign slack    = lower - fe;
   assign in_range = sweep_ctl.last || (lower < ent_dl);
   assign fail     = (sweep_ctl.step || sweep_ctl.last) && in_range &&
                     (lower <= dl_limit) && (acc_ff > DW'(slack));
   assign take     = sweep_ctl.step && (ent_rel >= lo) && (ent_dl <= dl_limit);

   always_comb begin
      acc_in       = acc_ff;
      prev_dl_in   = prev_dl_ff;
      have_prev_in = have_prev_ff;
      if (sweep_ctl.start) begin
         acc_in       = '0;
         have_prev_in = 1'b0;
      end else if (sweep_ctl.step) begin
         if (take) begin
            acc_in = acc_ff + DW'(ent_dur);
         end
         prev_dl_in   = ent_dl;
         have_prev_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      prev_dl_ff <= prev_dl_in;
   end

endmodule

>>> sv/dbat_ctrl.sv
// sequencer and deadline-sorted window memory of the admission test
module dbat_ctrl #(
   parameter int MAX_WINDOWS = 64,
   parameter int SLOT_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   dbat_req_chan.sink              req_ch,
   dbat_rsp_chan.source            rsp_ch,
   output dbat_pkg::sweep_ctl_type sweep_ctl,
   output logic [SLOT_BITS-1:0]    lo,
   output logic [SLOT_BITS-1:0]    fe,
   output logic [SLOT_BITS-1:0]    dl_limit,
   output logic [SLOT_BITS-1:0]    ent_rel,
   output logic [SLOT_BITS-1:0]    ent_dl,
   output logic [SLOT_BITS-1:0]    ent_dur,
   input  logic                    fail
);

   localparam int SW = SLOT_BITS;
   localparam int WW = 3 * SLOT_BITS;
   localparam int AW = $clog2(MAX_WINDOWS);
   localparam int CW = $clog2(MAX_WINDOWS + 1);
   localparam int CB = dbat_pkg::COUNT_BITS;
   localparam logic [CW-1:0] FULL = CW'(MAX_WINDOWS);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INS_CHK  = 4'd1;
   localparam logic [3:0] S_INS_MOVE = 4'd2;
   localparam logic [3:0] S_TST_PRE  = 4'd3;
   localparam logic [3:0] S_SW_BEGIN = 4'd4;
   localparam logic [3:0] S_SW_RUN   = 4'd5;
   localparam logic [3:0] S_SW_LAST  = 4'd6;
   localparam logic [3:0] S_ST_NEXT  = 4'd7;
   localparam logic [3:0] S_ST_CHK   = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   // window table, kept sorted by ascending deadline: {release, deadline, duration}
   logic [WW-1:0] mem [MAX_WINDOWS];
   logic [WW-1:0] rdata_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;
   logic          wr_en;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] sidx_ff, sidx_in;
   logic [CW-1:0] k_ff, k_in;
   logic [SW-1:0] r_ff, r_in;
   logic [SW-1:0] d_ff, d_in;
   logic [SW-1:0] c_ff, c_in;
   logic [SW-1:0] latest_ff, latest_in;
   logic [SW-1:0] lo_ff, lo_in;
   logic [SW-1:0] fe_ff, fe_in;
   logic          feas_ff, feas_in;
   logic          ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_feas_ff, rsp_feas_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic [CB-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [CW-1:0] sidx_dec;
   logic [CW-1:0] k_inc;

   assign ent_rel  = rdata_ff[WW-1 -: SW];
   assign ent_dl   = rdata_ff[2*SW-1 -: SW];
   assign ent_dur  = rdata_ff[SW-1:0];
   assign lo       = lo_ff;
   assign fe       = fe_ff;
   assign dl_limit = d_ff;

   assign sidx_dec = sidx_ff - CW'(1);
   assign k_inc    = k_ff + CW'(1);
   assign wr_addr  = sidx_ff[AW-1:0];

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.feasible     = rsp_feas_ff;
   assign rsp_ch.overflow     = rsp_ovf_ff;
   assign rsp_ch.window_count = rsp_cnt_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sidx_in      = sidx_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      d_in         = d_ff;
      c_in         = c_ff;
      latest_in    = latest_ff;
      lo_in        = lo_ff;
      fe_in        = fe_ff;
      feas_in      = feas_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_feas_in  = rsp_feas_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_data      = {r_ff, d_ff, c_ff};
      sweep_ctl    = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               r_in    = SW'(req_ch.release_req);
               d_in    = SW'(req_ch.deadline);
               c_in    = SW'(req_ch.duration);
               feas_in = 1'b0;
               ovf_in  = 1'b0;
               case (req_ch.mode)
                  dbat_pkg::MODE_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  dbat_pkg::MODE_INSERT: begin
                     if (count_ff == FULL) begin
                        ovf_in   = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        sidx_in  = count_ff;
                        state_in = S_INS_CHK;
                     end
                  end
                  dbat_pkg::MODE_TEST: begin
                     state_in = S_TST_PRE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // shift later-deadline entries up one place until the new window fits
         S_INS_CHK: begin
            if (sidx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end else begin
               rd_addr  = sidx_dec[AW-1:0];
               state_in = S_INS_MOVE;
            end
         end
         S_INS_MOVE: begin
            wr_en = 1'b1;
            if (ent_dl > d_ff) begin
               wr_data  = rdata_ff;
               sidx_in  = sidx_dec;
               state_in = S_INS_CHK;
            end else begin
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end
         end
         S_TST_PRE: begin
            if ((d_ff <= r_ff) || (c_ff == '0)) begin
               state_in = S_DONE;
            end else if ((d_ff - r_ff) < c_ff) begin
               feas_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               // first start is the latest one, d - C
               latest_in = d_ff - c_ff;
               lo_in     = d_ff - c_ff;
               fe_in     = d_ff;
               sidx_in   = '0;
               state_in  = S_SW_BEGIN;
            end
         end
         S_SW_BEGIN: begin
            sweep_ctl.start = 1'b1;
            k_in            = '0;
            if (count_ff == '0) begin
               state_in = S_SW_LAST;
            end else begin
               rd_addr  = '0;
               state_in = S_SW_RUN;
            end
         end
         S_SW_RUN: begin
            sweep_ctl.step = 1'b1;
            if (fail) begin
               state_in = S_DONE;
            end else begin
               k_in = k_inc;
               if (k_inc == count_ff) begin
                  state_in = S_SW_LAST;
               end else begin
                  rd_addr = k_inc[AW-1:0];
               end
            end
         end
         S_SW_LAST: begin
            sweep_ctl.last = 1'b1;
            if (fail) begin
               state_in = S_DONE;
            end else begin
               state_in = S_ST_NEXT;
            end
         end
         S_ST_NEXT: begin
            if (sidx_ff == count_ff) begin
               feas_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = sidx_ff[AW-1:0];
               state_in = S_ST_CHK;
            end
         end
         // a stored release is a start only inside [r, d - C] with its deadline <= d
         S_ST_CHK: begin
            sidx_in = sidx_ff + CW'(1);
            if ((ent_dl <= d_ff) && (ent_rel >= r_ff) && (ent_rel <= latest_ff)) begin
               lo_in    = ent_rel;
               fe_in    = ent_rel + c_ff;
               state_in = S_SW_BEGIN;
            end else begin
               state_in = S_ST_NEXT;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_feas_in  = feas_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_cnt_in   = CB'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sidx_ff     <= sidx_in;
      k_ff        <= k_in;
      r_ff        <= r_in;
      d_ff        <= d_in;
      c_ff        <= c_in;
      latest_ff   <= latest_in;
      lo_ff       <= lo_in;
      fe_ff       <= fe_in;
      feas_ff     <= feas_in;
      ovf_ff      <= ovf_in;
      rsp_feas_ff <= rsp_feas_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

endmodule

>>> sv/demand_bound_admission_test.sv
// top level of the demand bound admission test over a table of execution windows
//
//   channel  direction  handshake     payload
//   req_ch   in         valid/ready   mode, release_req, deadline, duration
//   rsp_ch   out        valid/ready   feasible, overflow, window_count
//
// clear and unused modes go straight to the result; insert moves stored windows
// by the read-then-write shift that keeps the memory sorted by deadline.
// test sweeps the window memory once for each start slot, one entry per cycle
// through its single read port into one demand accumulator.
// reset empties the table by clearing the count; memory contents are not cleared.
// the result register holds an item until taken; the next item is accepted meanwhile.
module demand_bound_admission_test #(
   parameter int MAX_WINDOWS = 64,
   parameter int SLOT_BITS   = 16
) (
   input logic          clock,
   input logic          reset,
   dbat_req_chan.sink   req_ch,
   dbat_rsp_chan.source rsp_ch
);

   dbat_pkg::sweep_ctl_type sweep_ctl;
   logic [SLOT_BITS-1:0]    lo;
   logic [SLOT_BITS-1:0]    fe;
   logic [SLOT_BITS-1:0]    dl_limit;
   logic [SLOT_BITS-1:0]    ent_rel;
   logic [SLOT_BITS-1:0]    ent_dl;
   logic [SLOT_BITS-1:0]    ent_dur;
   logic                    fail;

   dbat_ctrl #(
      .MAX_WINDOWS (MAX_WINDOWS),
      .SLOT_BITS   (SLOT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .sweep_ctl (sweep_ctl),
      .lo        (lo),
      .fe        (fe),
      .dl_limit  (dl_limit),
      .ent_rel   (ent_rel),
      .ent_dl    (ent_dl),
      .ent_dur   (ent_dur),
      .fail      (fail)
   );

   dbat_check #(
      .MAX_WINDOWS (MAX_WINDOWS),
      .SLOT_BITS   (SLOT_BITS)
   ) u_check (
      .clock     (clock),
      .reset     (reset),
      .sweep_ctl (sweep_ctl),
      .lo        (lo),
      .fe        (fe),
      .dl_limit  (dl_limit),
      .ent_rel   (ent_rel),
      .ent_dl    (ent_dl),
      .ent_dur   (ent_dur),
      .fail      (fail)
   );

`ifndef SYNTHESIS
   // sweep steps never overlap
   a_sweep_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({sweep_ctl.start, sweep_ctl.step, sweep_ctl.last}))
      else $error("sweep control has more than one step active");

   // an accepted item closes the request side in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while previous item still in work");

   a_result_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.feasible && rsp_ch.overflow))
      else $error("result flags both feasible and overflow");

   // a dropped insert only happens with a full table
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.overflow) |->
         (rsp_ch.window_count == dbat_pkg::COUNT_BITS'(MAX_WINDOWS)))
      else $error("overflow reported with table not full");
`endif

endmodule
